@@ rtl/core/assert_macros.svh @@
// assertion helpers included by the sequencer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/tps_pkg.sv @@
package tps_pkg;

  // sequencer state codes
  typedef enum logic [3:0] {
    ST_INIT  = 4'd0,
    ST_UP_A  = 4'd1,
    ST_UP_B  = 4'd2,
    ST_UP_C  = 4'd3,
    ST_OK    = 4'd4,
    ST_DN_C  = 4'd5,
    ST_DN_B  = 4'd6,
    ST_DN_A  = 4'd7,
    ST_FAULT = 4'd8,
    ST_OFF   = 4'd9
  } tps_state_t;

  localparam int unsigned PG_TIMEOUT_W = 16;
  localparam logic [PG_TIMEOUT_W-1:0] PG_TIMEOUT_RESET = 16'd1000;

  // one input request
  typedef struct packed {
    logic power_enable;
    logic emergency_off;
    logic good_3v3;
    logic good_0v9;
    logic good_1v8;
  } tps_in_t;

  // one result
  typedef struct packed {
    logic [3:0] state_code;
    logic       drive_3v3;
    logic       drive_0v9;
    logic       drive_1v8;
    logic       rails_up;
    logic       power_fault;
    logic [3:0] fault_origin;
    logic       seen_3v3;
    logic       seen_0v9;
    logic       seen_1v8;
  } tps_out_t;

  // sequencer state, bit 0 of rail vectors is 3v3, bit 1 0v9, bit 2 1v8
  typedef struct packed {
    tps_state_t              seq_state;
    logic [PG_TIMEOUT_W-1:0] wait_count;
    logic [2:0]              rail_drives;
    logic [2:0]              good_latched;
    logic [3:0]              fault_at;
    logic                    ok_flag;
    logic                    fault_flag;
  } tps_regs_t;

  localparam tps_regs_t REGS_RESET = '{
    seq_state:    ST_INIT,
    wait_count:   PG_TIMEOUT_RESET,
    rail_drives:  3'b000,
    good_latched: 3'b000,
    fault_at:     4'd0,
    ok_flag:      1'b0,
    fault_flag:   1'b0
  };

endpackage

@@ rtl/core/tps_step.sv @@
module tps_step (
  input  tps_pkg::tps_regs_t                    cur,
  input  logic [tps_pkg::PG_TIMEOUT_W-1:0]      pg_timeout,
  input  tps_pkg::tps_in_t                      item,
  output tps_pkg::tps_regs_t                    nxt
);
  import tps_pkg::*;

  // rail bit handled by a ramp state
  function automatic logic [2:0] rail_mask(input tps_state_t st);
    logic [2:0] m;
    case (st) inside
      ST_UP_A, ST_DN_A: m = 3'b001;
      ST_UP_B, ST_DN_B: m = 3'b010;
      default:          m = 3'b100;
    endcase
    return m;
  endfunction

  // successor along the ramp chains
  function automatic tps_state_t ramp_succ(input tps_state_t st);
    tps_state_t s;
    case (st)
      ST_UP_A: s = ST_UP_B;
      ST_UP_B: s = ST_UP_C;
      ST_UP_C: s = ST_OK;
      ST_DN_C: s = ST_DN_B;
      ST_DN_B: s = ST_DN_A;
      default: s = ST_OFF;
    endcase
    return s;
  endfunction

  logic       en;
  logic       epo;
  logic [2:0] good;
  logic [2:0] mask;
  logic       rail_good;
  logic [2:0] first_low;
  tps_state_t state_nxt;

  assign en        = item.power_enable;
  assign epo       = item.emergency_off;
  assign good      = {item.good_1v8, item.good_0v9, item.good_3v3};
  assign mask      = rail_mask(cur.seq_state);
  assign rail_good = |(good & mask);
  assign first_low = !good[0] ? 3'b001 : (!good[1] ? 3'b010 : 3'b100);

  // next state
  always_comb begin
    unique case (cur.seq_state) inside
      ST_INIT: begin
        state_nxt = (en && !epo) ? ST_UP_A : ST_INIT;
      end
      ST_UP_A, ST_UP_B, ST_UP_C: begin
        if (!en || epo) begin
          state_nxt = ST_OFF;
        end else if (rail_good) begin
          state_nxt = ramp_succ(cur.seq_state);
        end else if (cur.wait_count != '0) begin
          state_nxt = cur.seq_state;
        end else begin
          state_nxt = ST_FAULT;
        end
      end
      ST_OK: begin
        if (epo) begin
          state_nxt = ST_OFF;
        end else if (!en) begin
          state_nxt = ST_DN_C;
        end else begin
          state_nxt = (&good) ? ST_OK : ST_FAULT;
        end
      end
      ST_DN_C, ST_DN_B, ST_DN_A: begin
        if (epo) begin
          state_nxt = ST_OFF;
        end else if (!rail_good) begin
          state_nxt = ramp_succ(cur.seq_state);
        end else begin
          state_nxt = cur.seq_state;
        end
      end
      ST_FAULT: begin
        state_nxt = (!en || epo) ? ST_OFF : ST_FAULT;
      end
      default: begin
        state_nxt = (epo || !en) ? ST_INIT : ST_OFF;
      end
    endcase
  end

  // counters, drives and status flags
  always_comb begin
    nxt           = cur;
    nxt.seq_state = state_nxt;
    unique case (cur.seq_state) inside
      ST_INIT: begin
        nxt.wait_count = pg_timeout;
        nxt.ok_flag    = 1'b0;
        nxt.fault_flag = 1'b0;
        nxt.fault_at   = 4'(ST_INIT);
      end
      ST_UP_A, ST_UP_B, ST_UP_C: begin
        nxt.rail_drives = cur.rail_drives | mask;
        if (en && !epo) begin
          if (rail_good) begin
            nxt.good_latched = cur.good_latched | mask;
            nxt.wait_count   = pg_timeout;
          end else if (cur.wait_count != '0) begin
            nxt.wait_count = cur.wait_count - 1'b1;
          end else begin
            nxt.fault_at = cur.seq_state;
          end
        end
      end
      ST_OK: begin
        nxt.ok_flag = 1'b1;
        if (!epo && en && !(&good)) begin
          nxt.good_latched = cur.good_latched & ~first_low;
          nxt.fault_at     = ST_OK;
        end
      end
      ST_DN_C, ST_DN_B, ST_DN_A: begin
        nxt.ok_flag     = 1'b0;
        nxt.rail_drives = cur.rail_drives & ~mask;
        if (!epo && !rail_good) begin
          nxt.good_latched = cur.good_latched & ~mask;
        end
      end
      ST_FAULT: begin
        nxt.rail_drives = 3'b000;
        nxt.ok_flag     = 1'b0;
        nxt.fault_flag  = 1'b1;
      end
      default: begin
        nxt.rail_drives = 3'b000;
        nxt.ok_flag     = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/three_rail_power_sequencer_core.sv @@
// Three-rail power sequencer: brings up the 3.3V, 0.9V and 1.8V regulators
// in that order, watching each power-good with a timeout, and ramps them down
// in reverse order when power_enable drops.
// Input channel (in_valid/in_ready/in_data): one request per control tick,
// carrying power_enable, emergency_off and the three power-good pins.
// Result channel (out_valid/out_ready/out_data): one result per request,
// the sequencer state, regulator drives and status after that tick.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes pg_timeout, always
// ready; write it only while no request is in flight.
// A request accepted into the input register moves on into the result register,
// and so to the output, once the result register is free or being taken.
// Throughput is one request per clock while out_ready stays high, the input
// register feeding a combinational state update into the result register.
// When out_ready is low the result register holds, the input register fills,
// and in_ready drops until the result is taken.
// Reset (rst_n low at a clock edge) returns the sequencer to init with all
// drives off, empties both registers and sets pg_timeout to 1000.
module three_rail_power_sequencer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tps_pkg::tps_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tps_pkg::tps_out_t                     out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tps_pkg::PG_TIMEOUT_W-1:0]      cfg_data
);
  import tps_pkg::*;

  logic                    s1_valid_r;
  tps_in_t                 s1_data_r;
  logic                    out_valid_r;
  tps_out_t                out_data_r;
  tps_out_t                out_data_nxt;
  tps_regs_t               regs_r;
  tps_regs_t               regs_nxt;
  logic [PG_TIMEOUT_W-1:0] pg_timeout_r;
  logic                    adv;

  // request moves from input register to result register
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one tick of the sequencer
  tps_step u_step (
    .cur        (regs_r),
    .pg_timeout (pg_timeout_r),
    .item       (s1_data_r),
    .nxt        (regs_nxt)
  );

  // result fields from the updated state
  always_comb begin
    out_data_nxt.state_code   = regs_nxt.seq_state;
    out_data_nxt.drive_3v3    = regs_nxt.rail_drives[0];
    out_data_nxt.drive_0v9    = regs_nxt.rail_drives[1];
    out_data_nxt.drive_1v8    = regs_nxt.rail_drives[2];
    out_data_nxt.rails_up     = regs_nxt.ok_flag;
    out_data_nxt.power_fault  = regs_nxt.fault_flag;
    out_data_nxt.fault_origin = regs_nxt.fault_at;
    out_data_nxt.seen_3v3     = regs_nxt.good_latched[0];
    out_data_nxt.seen_0v9     = regs_nxt.good_latched[1];
    out_data_nxt.seen_1v8     = regs_nxt.good_latched[2];
  end

  // control and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      regs_r       <= REGS_RESET;
      pg_timeout_r <= PG_TIMEOUT_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        regs_r      <= regs_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        pg_timeout_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_ready_when_empty, !out_valid_r |-> in_ready, "input stalled with empty output")
  `ASSERT_CLK(a_state_holds, !adv |=> $stable(regs_r), "state changed without a request")
  `ASSERT_NEVER(a_init_drives_off, regs_r.seq_state == ST_INIT && regs_r.rail_drives != 3'b000, "drives on in init")
  `ASSERT_NEVER(a_fault_origin, regs_r.fault_flag && regs_r.fault_at == 4'd0, "fault without origin")

endmodule
